/* hw/rtl/ipdcd_pkg.sv */
// shared types, constants and helpers of the pulse-distance ir command decoder
package ipdcd_pkg;

    localparam int CNT_W           = 20;
    localparam int CODE_W          = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int FRAME_DEPTH_DEF = 64;
    localparam int BIT_BASE        = 17;
    localparam int CMD_BITS        = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CNT_W-1:0]  TIMEOUT_RST     = 20'd1000000;
    localparam logic [CNT_W-1:0]  LEADER_LOW_RST  = 20'd10000;
    localparam logic [CNT_W-1:0]  LEADER_HIGH_RST = 20'd14000;
    localparam logic [CNT_W-1:0]  ONE_LOW_RST     = 20'd2000;
    localparam logic [CNT_W-1:0]  ONE_HIGH_RST    = 20'd2300;
    localparam logic [CODE_W-1:0] ON_CODE_RST     = 8'd70;
    localparam logic [CODE_W-1:0] OFF_CODE_RST    = 8'd69;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMEOUT     = 3'd0,
        REG_LEADER_LOW  = 3'd1,
        REG_LEADER_HIGH = 3'd2,
        REG_ONE_LOW     = 3'd3,
        REG_ONE_HIGH    = 3'd4,
        REG_ON_CODE     = 3'd5,
        REG_OFF_CODE    = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [CNT_W-1:0]  timeout_ticks;
        logic [CNT_W-1:0]  leader_low;
        logic [CNT_W-1:0]  leader_high;
        logic [CNT_W-1:0]  one_low;
        logic [CNT_W-1:0]  one_high;
        logic [CODE_W-1:0] on_code;
        logic [CODE_W-1:0] off_code;
    } cfg_t;

    function automatic logic in_range(input logic [CNT_W-1:0] v,
                                      input logic [CNT_W-1:0] lo,
                                      input logic [CNT_W-1:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

endpackage

/* hw/rtl/ipdcd_cfg.sv */
// configuration register file of the ir command decoder
module ipdcd_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ipdcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ipdcd_pkg::CNT_W-1:0]     cfg_data,
    output ipdcd_pkg::cfg_t                 cfg
);

    ipdcd_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ticks <= ipdcd_pkg::TIMEOUT_RST;
            cfg_reg.leader_low    <= ipdcd_pkg::LEADER_LOW_RST;
            cfg_reg.leader_high   <= ipdcd_pkg::LEADER_HIGH_RST;
            cfg_reg.one_low       <= ipdcd_pkg::ONE_LOW_RST;
            cfg_reg.one_high      <= ipdcd_pkg::ONE_HIGH_RST;
            cfg_reg.on_code       <= ipdcd_pkg::ON_CODE_RST;
            cfg_reg.off_code      <= ipdcd_pkg::OFF_CODE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                ipdcd_pkg::REG_TIMEOUT:     cfg_reg.timeout_ticks <= cfg_data;
                ipdcd_pkg::REG_LEADER_LOW:  cfg_reg.leader_low    <= cfg_data;
                ipdcd_pkg::REG_LEADER_HIGH: cfg_reg.leader_high   <= cfg_data;
                ipdcd_pkg::REG_ONE_LOW:     cfg_reg.one_low       <= cfg_data;
                ipdcd_pkg::REG_ONE_HIGH:    cfg_reg.one_high      <= cfg_data;
                ipdcd_pkg::REG_ON_CODE: begin
                    cfg_reg.on_code <= cfg_data[ipdcd_pkg::CODE_W-1:0];
                end
                ipdcd_pkg::REG_OFF_CODE: begin
                    cfg_reg.off_code <= cfg_data[ipdcd_pkg::CODE_W-1:0];
                end
                default: ;
            endcase
        end
    end

endmodule

/* hw/rtl/ipdcd_store.sv */
// interval memory, one write and one registered read port, entries read zero until written
module ipdcd_store #(
    parameter int DEPTH = ipdcd_pkg::FRAME_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [ipdcd_pkg::CNT_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [ipdcd_pkg::CNT_W-1:0] rd_data
);

    logic [ipdcd_pkg::CNT_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]            written_reg;
    logic [ipdcd_pkg::CNT_W-1:0] rd_data_reg;
    logic                        rd_written_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_written_reg ? rd_data_reg : '0;

endmodule

/* hw/rtl/ipdcd_seq.sv */
// tick sequencer: interval capture, frame-end scan of the interval memory and result register
module ipdcd_seq #(
    parameter int DEPTH = ipdcd_pkg::FRAME_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int IW    = $clog2(DEPTH + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ipdcd_pkg::cfg_t              cfg,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_falling_edge,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_led_level,
    output logic [ipdcd_pkg::CODE_W-1:0] m_command_byte,
    output logic                         m_frame_done,
    output logic                         m_frame_valid,
    output logic                         wr_en,
    output logic [AW-1:0]                wr_addr,
    output logic [ipdcd_pkg::CNT_W-1:0]  wr_data,
    output logic                         rd_en,
    output logic [AW-1:0]                rd_addr,
    input  logic [ipdcd_pkg::CNT_W-1:0]  rd_data
);

    localparam logic [3:0] SCAN_LAST = 4'(ipdcd_pkg::CMD_BITS + 1);
    localparam logic [3:0] SCAN_READS = 4'(ipdcd_pkg::CMD_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_PUSH
    } state_t;

    state_t                         state_reg;
    logic                           started_reg;
    logic [ipdcd_pkg::CNT_W-1:0]    tick_reg;
    logic [ipdcd_pkg::CNT_W-1:0]    tick_next;
    logic [IW-1:0]                  idx_reg;
    logic [3:0]                     scan_reg;
    logic [ipdcd_pkg::CODE_W-1:0]   cmd_reg;
    logic                           leader_ok_reg;
    logic                           done_reg;
    logic [ipdcd_pkg::CODE_W-1:0]   decoded_reg;
    logic                           led_reg;
    logic                           m_valid_reg;
    logic                           m_led_level_reg;
    logic [ipdcd_pkg::CODE_W-1:0]   m_command_byte_reg;
    logic                           m_frame_done_reg;
    logic                           m_frame_valid_reg;
    logic                           accept;
    logic                           room;
    logic [2:0]                     bit_sel;

    assign s_ready        = (state_reg == ST_IDLE);
    assign accept         = s_valid && s_ready;
    assign room           = (idx_reg < IW'(DEPTH));
    assign tick_next      = (started_reg && tick_reg != ipdcd_pkg::CNT_MAX)
                            ? tick_reg + 1'b1 : tick_reg;
    assign bit_sel        = 3'(scan_reg - 4'd2);

    assign m_valid        = m_valid_reg;
    assign m_led_level    = m_led_level_reg;
    assign m_command_byte = m_command_byte_reg;
    assign m_frame_done   = m_frame_done_reg;
    assign m_frame_valid  = m_frame_valid_reg;

    // capture write on an edge, clear of interval 0 at frame end
    always_comb begin
        wr_en   = (accept && s_falling_edge && started_reg && room)
                  || (state_reg == ST_FINISH);
        wr_addr = (state_reg == ST_FINISH) ? '0 : idx_reg[AW-1:0];
        wr_data = (state_reg == ST_FINISH) ? '0 : tick_next;
        rd_en   = (state_reg == ST_SCAN) && (scan_reg <= SCAN_READS);
        rd_addr = (scan_reg == 4'd0) ? '0
                  : AW'(ipdcd_pkg::BIT_BASE - 1) + AW'(scan_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            started_reg       <= 1'b0;
            tick_reg          <= '0;
            idx_reg           <= '0;
            scan_reg          <= '0;
            cmd_reg           <= '0;
            leader_ok_reg     <= 1'b0;
            done_reg          <= 1'b0;
            decoded_reg       <= '0;
            led_reg           <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (m_ready && state_reg != ST_PUSH) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        done_reg      <= 1'b0;
                        leader_ok_reg <= 1'b0;
                        if (s_falling_edge) begin
                            started_reg <= 1'b1;
                            if (started_reg && room) begin
                                idx_reg <= idx_reg + 1'b1;
                            end
                            tick_reg  <= '0;
                            state_reg <= ST_PUSH;
                        end else if (started_reg && tick_next >= cfg.timeout_ticks) begin
                            tick_reg  <= tick_next;
                            scan_reg  <= '0;
                            cmd_reg   <= '0;
                            state_reg <= ST_SCAN;
                        end else begin
                            tick_reg  <= tick_next;
                            state_reg <= ST_PUSH;
                        end
                    end
                end
                ST_SCAN: begin
                    // read data of the previous step arrives here
                    if (scan_reg == 4'd1) begin
                        leader_ok_reg <= ipdcd_pkg::in_range(rd_data, cfg.leader_low,
                                                             cfg.leader_high);
                    end
                    if (scan_reg >= 4'd2) begin
                        cmd_reg[bit_sel] <= ipdcd_pkg::in_range(rd_data, cfg.one_low,
                                                                cfg.one_high);
                    end
                    scan_reg <= scan_reg + 1'b1;
                    if (scan_reg == SCAN_LAST) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    started_reg <= 1'b0;
                    idx_reg     <= '0;
                    tick_reg    <= '0;
                    done_reg    <= 1'b1;
                    decoded_reg <= leader_ok_reg ? cmd_reg : '0;
                    if (leader_ok_reg) begin
                        if (cmd_reg == cfg.on_code) begin
                            led_reg <= 1'b1;
                        end else if (cmd_reg == cfg.off_code) begin
                            led_reg <= 1'b0;
                        end
                    end
                    state_reg <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg        <= 1'b1;
                        m_led_level_reg    <= led_reg;
                        m_command_byte_reg <= decoded_reg;
                        m_frame_done_reg   <= done_reg;
                        m_frame_valid_reg  <= done_reg && leader_ok_reg;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= IW'(DEPTH))
        else $error("edge index past store depth");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_en && wr_en))
        else $error("interval memory read and write in one cycle");

    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FINISH |=> !started_reg && idx_reg == '0 && tick_reg == '0)
        else $error("frame end did not clear frame state");

    a_valid_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_frame_valid_reg |-> m_frame_done_reg)
        else $error("frame valid without frame done");

endmodule

/* hw/rtl/ir_pulse_distance_command_decoder_core.sv */
// top level of the pulse-distance ir command decoder
// One input word is one microsecond tick carrying a falling-edge flag; each tick returns one
// result word with the led level, the last decoded command and the frame done/valid flags.
// A tick that does not end a frame is accepted, then loaded into the output register once it is free.
// A tick that ends a frame starts a scan: the interval memory has a single read port, so the
// leader interval and the eight command intervals are read one per cycle, followed by the
// write-back that clears interval 0 and the output load. Results wait in an output register, so
// the next tick is taken while the previous result is still pending. Configuration writes are
// taken every cycle and must only be issued while no tick is in flight. No memory clearing pass
// is needed after reset: each memory entry has a flop marking it written and reads zero before.
module ir_pulse_distance_command_decoder_core #(
    parameter int FRAME_DEPTH = ipdcd_pkg::FRAME_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ipdcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ipdcd_pkg::CNT_W-1:0]     cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_falling_edge,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_led_level,
    output logic [ipdcd_pkg::CODE_W-1:0]    m_command_byte,
    output logic                            m_frame_done,
    output logic                            m_frame_valid
);

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int IW = $clog2(FRAME_DEPTH + 1);

    ipdcd_pkg::cfg_t             cfg;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [ipdcd_pkg::CNT_W-1:0] wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [ipdcd_pkg::CNT_W-1:0] rd_data;

    ipdcd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ipdcd_store #(
        .DEPTH (FRAME_DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ipdcd_seq #(
        .DEPTH (FRAME_DEPTH),
        .AW    (AW),
        .IW    (IW)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_falling_edge (s_falling_edge),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_led_level    (m_led_level),
        .m_command_byte (m_command_byte),
        .m_frame_done   (m_frame_done),
        .m_frame_valid  (m_frame_valid),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data)
    );

endmodule
